[rtl/ppd_pkg.sv]
// Shared constants, register indexes and types for the periodic pair distance block.
// No dependencies; every other file of the block imports this package.
package ppd_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int BOX_W       = 31;
    localparam int INV_W       = 32;
    localparam int ROUND_FRAC  = 44;
    localparam int PROD_W      = DIFF_W + INV_W;
    localparam int KM_W        = PROD_W + 1 - ROUND_FRAC;
    localparam int BP_W        = BOX_W + KM_W;
    localparam int ADJ_W       = BP_W + 2;
    localparam int SQ_W        = 2 * COORD_WIDTH + 2;
    localparam int DSQ_W       = 64;
    localparam int DIST_W      = 32;
    localparam int REM_W       = 36;
    localparam int ROOT_STEPS  = 32;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_REM_W   = DIST_W + 1;
    localparam int DIV_SAT     = 256;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PERIODIC = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Z    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_Z    = 3'd6;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] sep_x;
        logic [COORD_WIDTH-1:0] sep_y;
        logic [COORD_WIDTH-1:0] sep_z;
        logic [DSQ_W-1:0]       dist_sq;
    } side_t;

endpackage

[rtl/ppd_if.sv]
// Channel interfaces for the periodic pair distance block: input, result and register write.
// Depends on ppd_pkg.
interface ppd_in_if;
    import ppd_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] pos_ix;
    logic signed [COORD_WIDTH-1:0] pos_iy;
    logic signed [COORD_WIDTH-1:0] pos_iz;
    logic signed [COORD_WIDTH-1:0] pos_jx;
    logic signed [COORD_WIDTH-1:0] pos_jy;
    logic signed [COORD_WIDTH-1:0] pos_jz;
    modport source (output valid, pos_ix, pos_iy, pos_iz, pos_jx, pos_jy, pos_jz,
                    input ready);
    modport sink (input valid, pos_ix, pos_iy, pos_iz, pos_jx, pos_jy, pos_jz,
                  output ready);
endinterface

interface ppd_out_if;
    import ppd_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] sep_x;
    logic signed [COORD_WIDTH-1:0] sep_y;
    logic signed [COORD_WIDTH-1:0] sep_z;
    logic [DSQ_W-1:0]              dist_sq;
    logic [DIST_W-1:0]             dist_res;
    logic [DIST_W-1:0]             inv_dist;
    logic                          coincident;
    modport source (output valid, sep_x, sep_y, sep_z, dist_sq, dist_res, inv_dist,
                    coincident, input ready);
    modport sink (input valid, sep_x, sep_y, sep_z, dist_sq, dist_res, inv_dist,
                  coincident, output ready);
endinterface

interface ppd_cfg_if;
    import ppd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/ppd_wrap.sv]
// Four-stage minimum-image wrap of one axis: difference, rounding product, box
// multiple and clamp. Depends on ppd_pkg.
module ppd_wrap (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic                                  periodic,
    input  logic [ppd_pkg::BOX_W-1:0]             box,
    input  logic [ppd_pkg::INV_W-1:0]             inv_box,
    input  logic signed [ppd_pkg::COORD_WIDTH-1:0] pos_i,
    input  logic signed [ppd_pkg::COORD_WIDTH-1:0] pos_j,
    output logic signed [ppd_pkg::COORD_WIDTH-1:0] sep
);
    import ppd_pkg::*;

    localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1) << (ROUND_FRAC - 1);
    localparam logic signed [ADJ_W-1:0] SEP_MAX =
        {{(ADJ_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [ADJ_W-1:0] SEP_MIN = ~SEP_MAX;

    logic signed [DIFF_W-1:0]      d;
    logic [DIFF_W-1:0]             mag;
    logic [PROD_W-1:0]             prod;
    logic [PROD_W:0]               rsum;
    logic [BP_W-1:0]               bp;
    logic signed [ADJ_W-1:0]       wide;
    logic signed [ADJ_W-1:0]       adj;
    logic signed [COORD_WIDTH-1:0] sep_next;

    logic signed [DIFF_W-1:0]      d1_reg, d2_reg, d3_reg;
    logic [PROD_W-1:0]             prod1_reg;
    logic [KM_W-1:0]               km2_reg;
    logic [BP_W-1:0]               bp3_reg;
    logic signed [COORD_WIDTH-1:0] sep_reg;

    assign d    = {pos_i[COORD_WIDTH-1], pos_i} - {pos_j[COORD_WIDTH-1], pos_j};
    assign mag  = d[DIFF_W-1] ? DIFF_W'(~d + 1'b1) : DIFF_W'(d);
    assign prod = PROD_W'(mag) * PROD_W'(inv_box);
    assign rsum = {1'b0, prod1_reg} + (d1_reg[DIFF_W-1] ? HALF : HALF - 1'b1);
    assign bp   = BP_W'(box) * BP_W'(km2_reg);
    assign wide = {{(ADJ_W - DIFF_W){d3_reg[DIFF_W-1]}}, d3_reg};

    always_comb
    begin
        if (!periodic)
        begin
            adj = wide;
        end
        else if (d3_reg[DIFF_W-1])
        begin
            adj = wide + $signed({2'b00, bp3_reg});
        end
        else
        begin
            adj = wide - $signed({2'b00, bp3_reg});
        end
        if (adj > SEP_MAX)
        begin
            sep_next = SEP_MAX[COORD_WIDTH-1:0];
        end
        else if (adj < SEP_MIN)
        begin
            sep_next = SEP_MIN[COORD_WIDTH-1:0];
        end
        else
        begin
            sep_next = adj[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg    <= d;
            prod1_reg <= prod;
            d2_reg    <= d1_reg;
            km2_reg   <= rsum[PROD_W:ROUND_FRAC];
            d3_reg    <= d2_reg;
            bp3_reg   <= bp;
            sep_reg   <= sep_next;
        end
    end

    assign sep = sep_reg;

endmodule

[rtl/ppd_root.sv]
// Pipelined square root (one result bit per stage) followed by a pipelined
// reciprocal division (one quotient bit per stage). Depends on ppd_pkg.
module ppd_root (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  ppd_pkg::side_t              in_side,
    output logic                        out_valid,
    output ppd_pkg::side_t              out_side,
    output logic [ppd_pkg::DIST_W-1:0]  dist_res,
    output logic [ppd_pkg::DIST_W-1:0]  inv_dist
);
    import ppd_pkg::*;

    logic              sq_valid_reg [ROOT_STEPS];
    side_t             sq_side_reg  [ROOT_STEPS];
    logic [REM_W-1:0]  sq_rem_reg   [ROOT_STEPS];
    logic [DIST_W-1:0] sq_root_reg  [ROOT_STEPS];
    logic [DSQ_W-1:0]  sq_bits_reg  [ROOT_STEPS];
    logic [REM_W-1:0]  sq_rem_next  [ROOT_STEPS];
    logic [DIST_W-1:0] sq_root_next [ROOT_STEPS];

    logic                 dv_valid_reg [DIV_STEPS];
    side_t                dv_side_reg  [DIV_STEPS];
    logic [DIST_W-1:0]    dv_dist_reg  [DIV_STEPS];
    logic [DIV_REM_W-1:0] dv_rem_reg   [DIV_STEPS];
    logic [DIST_W-1:0]    dv_q_reg     [DIV_STEPS];
    logic                 dv_sat_reg   [DIV_STEPS];
    logic [DIV_REM_W-1:0] dv_rem_next  [DIV_STEPS];
    logic [DIST_W-1:0]    dv_q_next    [DIV_STEPS];

    always_comb
    begin
        logic [REM_W-1:0]  src_rem;
        logic [DIST_W-1:0] src_root;
        logic [DSQ_W-1:0]  src_bits;
        logic [REM_W-1:0]  r;
        logic [REM_W-1:0]  t;
        for (int k = 0; k < ROOT_STEPS; k++)
        begin
            if (k == 0)
            begin
                src_rem  = '0;
                src_root = '0;
                src_bits = in_side.dist_sq;
            end
            else
            begin
                src_rem  = sq_rem_reg[k-1];
                src_root = sq_root_reg[k-1];
                src_bits = sq_bits_reg[k-1];
            end
            r = {src_rem[REM_W-3:0], src_bits[DSQ_W-1:DSQ_W-2]};
            t = {2'b00, src_root, 2'b01};
            if (r >= t)
            begin
                sq_rem_next[k]  = r - t;
                sq_root_next[k] = {src_root[DIST_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next[k]  = r;
                sq_root_next[k] = {src_root[DIST_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        logic [DIV_REM_W-1:0] src_rem;
        logic [DIST_W-1:0]    src_q;
        logic [DIST_W-1:0]    src_dist;
        logic [DIV_REM_W-1:0] r2;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if (k == 0)
            begin
                src_rem  = DIV_REM_W'(DIV_SAT);
                src_q    = '0;
                src_dist = sq_root_reg[ROOT_STEPS-1];
            end
            else
            begin
                src_rem  = dv_rem_reg[k-1];
                src_q    = dv_q_reg[k-1];
                src_dist = dv_dist_reg[k-1];
            end
            r2 = {src_rem[DIV_REM_W-2:0], 1'b0};
            if (r2 >= {1'b0, src_dist})
            begin
                dv_rem_next[k] = r2 - {1'b0, src_dist};
                dv_q_next[k]   = {src_q[DIST_W-2:0], 1'b1};
            end
            else
            begin
                dv_rem_next[k] = r2;
                dv_q_next[k]   = {src_q[DIST_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ROOT_STEPS; k++)
            begin
                sq_valid_reg[k] <= 1'b0;
            end
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                dv_valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            sq_valid_reg[0] <= in_valid;
            for (int k = 1; k < ROOT_STEPS; k++)
            begin
                sq_valid_reg[k] <= sq_valid_reg[k-1];
            end
            dv_valid_reg[0] <= sq_valid_reg[ROOT_STEPS-1];
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                dv_valid_reg[k] <= dv_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_side_reg[0] <= in_side;
            sq_bits_reg[0] <= {in_side.dist_sq[DSQ_W-3:0], 2'b00};
            for (int k = 1; k < ROOT_STEPS; k++)
            begin
                sq_side_reg[k] <= sq_side_reg[k-1];
                sq_bits_reg[k] <= {sq_bits_reg[k-1][DSQ_W-3:0], 2'b00};
            end
            for (int k = 0; k < ROOT_STEPS; k++)
            begin
                sq_rem_reg[k]  <= sq_rem_next[k];
                sq_root_reg[k] <= sq_root_next[k];
            end
            dv_side_reg[0] <= sq_side_reg[ROOT_STEPS-1];
            dv_dist_reg[0] <= sq_root_reg[ROOT_STEPS-1];
            dv_sat_reg[0]  <= sq_root_reg[ROOT_STEPS-1] <= DIST_W'(DIV_SAT);
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                dv_side_reg[k] <= dv_side_reg[k-1];
                dv_dist_reg[k] <= dv_dist_reg[k-1];
                dv_sat_reg[k]  <= dv_sat_reg[k-1];
            end
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                dv_rem_reg[k] <= dv_rem_next[k];
                dv_q_reg[k]   <= dv_q_next[k];
            end
        end
    end

    assign out_valid = dv_valid_reg[DIV_STEPS-1];
    assign out_side  = dv_side_reg[DIV_STEPS-1];
    assign dist_res  = dv_dist_reg[DIV_STEPS-1];
    assign inv_dist  = dv_sat_reg[DIV_STEPS-1] ? '1 : dv_q_reg[DIV_STEPS-1];

endmodule

[rtl/periodic_pair_distance.sv]
// Top level of the periodic pair distance block: register file, wrap lanes,
// squared distance stages and the root and reciprocal pipeline.
// Depends on ppd_pkg, ppd_if, ppd_wrap and ppd_root.
//
// Usage: in_ch carries a request of two points; out_ch returns their
// separation, squared distance, distance, inverse distance and a flag for
// coincident points. cfg_ch writes the mode, box lengths and inverse box
// lengths by index; it is always ready and should be used while the block
// is empty. Each request passes from acceptance to its result through the
// wrap, the squared distance stages, the square root (one result bit per
// stage) and the reciprocal (one quotient bit per stage). One request is
// accepted per cycle while no result is held off. The whole pipeline advances
// together; when the receiver holds off a waiting result, every stage holds
// and in_ch.ready is low until the result is taken. Reset clears all valid
// bits and returns the registers to zero (non-periodic, zero boxes).
module periodic_pair_distance (
    input  logic        clk,
    input  logic        rst_n,
    ppd_in_if.sink      in_ch,
    ppd_out_if.source   out_ch,
    ppd_cfg_if.sink     cfg_ch
);
    import ppd_pkg::*;

    logic              periodic_reg;
    logic [BOX_W-1:0]  box_x_reg, box_y_reg, box_z_reg;
    logic [INV_W-1:0]  inv_x_reg, inv_y_reg, inv_z_reg;

    logic en;
    logic root_valid;
    side_t root_side;
    logic [DIST_W-1:0] root_dist, root_inv;

    logic signed [COORD_WIDTH-1:0] wsep_x, wsep_y, wsep_z;
    logic [COORD_WIDTH-1:0] mag_x, mag_y, mag_z;
    logic [SQ_W-1:0] sq_sum;
    logic [SQ_W+DSQ_W-1:0] sq_ext;

    logic                   wv_reg [4];
    logic                   s5_valid_reg, s6_valid_reg;
    logic [COORD_WIDTH-1:0] s5_sep_x_reg, s5_sep_y_reg, s5_sep_z_reg;
    logic [2*COORD_WIDTH-1:0] s5_sq_x_reg, s5_sq_y_reg, s5_sq_z_reg;
    side_t                  s6_side_reg;
    side_t                  s6_side_next;

    assign en           = !out_ch.valid || out_ch.ready;
    assign in_ch.ready  = en;
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            periodic_reg <= 1'b0;
            box_x_reg    <= '0;
            box_y_reg    <= '0;
            box_z_reg    <= '0;
            inv_x_reg    <= '0;
            inv_y_reg    <= '0;
            inv_z_reg    <= '0;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_PERIODIC: periodic_reg <= cfg_ch.data[0];
                REG_BOX_X:    box_x_reg    <= cfg_ch.data[BOX_W-1:0];
                REG_BOX_Y:    box_y_reg    <= cfg_ch.data[BOX_W-1:0];
                REG_BOX_Z:    box_z_reg    <= cfg_ch.data[BOX_W-1:0];
                REG_INV_X:    inv_x_reg    <= cfg_ch.data[INV_W-1:0];
                REG_INV_Y:    inv_y_reg    <= cfg_ch.data[INV_W-1:0];
                REG_INV_Z:    inv_z_reg    <= cfg_ch.data[INV_W-1:0];
                default:      periodic_reg <= periodic_reg;
            endcase
        end
    end

    ppd_wrap u_wrap_x (
        .clk      (clk),
        .en       (en),
        .periodic (periodic_reg),
        .box      (box_x_reg),
        .inv_box  (inv_x_reg),
        .pos_i    (in_ch.pos_ix),
        .pos_j    (in_ch.pos_jx),
        .sep      (wsep_x)
    );

    ppd_wrap u_wrap_y (
        .clk      (clk),
        .en       (en),
        .periodic (periodic_reg),
        .box      (box_y_reg),
        .inv_box  (inv_y_reg),
        .pos_i    (in_ch.pos_iy),
        .pos_j    (in_ch.pos_jy),
        .sep      (wsep_y)
    );

    ppd_wrap u_wrap_z (
        .clk      (clk),
        .en       (en),
        .periodic (periodic_reg),
        .box      (box_z_reg),
        .inv_box  (inv_z_reg),
        .pos_i    (in_ch.pos_iz),
        .pos_j    (in_ch.pos_jz),
        .sep      (wsep_z)
    );

    assign mag_x = wsep_x[COORD_WIDTH-1] ? COORD_WIDTH'(~wsep_x + 1'b1) : COORD_WIDTH'(wsep_x);
    assign mag_y = wsep_y[COORD_WIDTH-1] ? COORD_WIDTH'(~wsep_y + 1'b1) : COORD_WIDTH'(wsep_y);
    assign mag_z = wsep_z[COORD_WIDTH-1] ? COORD_WIDTH'(~wsep_z + 1'b1) : COORD_WIDTH'(wsep_z);

    assign sq_sum = {2'b00, s5_sq_x_reg} + {2'b00, s5_sq_y_reg} + {2'b00, s5_sq_z_reg};
    assign sq_ext = {{DSQ_W{1'b0}}, sq_sum};

    always_comb
    begin
        s6_side_next.sep_x   = s5_sep_x_reg;
        s6_side_next.sep_y   = s5_sep_y_reg;
        s6_side_next.sep_z   = s5_sep_z_reg;
        s6_side_next.dist_sq = (|sq_ext[SQ_W+DSQ_W-1:DSQ_W]) ? '1 : sq_ext[DSQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                wv_reg[k] <= 1'b0;
            end
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            wv_reg[0] <= in_ch.valid;
            for (int k = 1; k < 4; k++)
            begin
                wv_reg[k] <= wv_reg[k-1];
            end
            s5_valid_reg <= wv_reg[3];
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_sep_x_reg <= wsep_x;
            s5_sep_y_reg <= wsep_y;
            s5_sep_z_reg <= wsep_z;
            s5_sq_x_reg  <= (2*COORD_WIDTH)'(mag_x) * (2*COORD_WIDTH)'(mag_x);
            s5_sq_y_reg  <= (2*COORD_WIDTH)'(mag_y) * (2*COORD_WIDTH)'(mag_y);
            s5_sq_z_reg  <= (2*COORD_WIDTH)'(mag_z) * (2*COORD_WIDTH)'(mag_z);
            s6_side_reg  <= s6_side_next;
        end
    end

    ppd_root u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s6_valid_reg),
        .in_side   (s6_side_reg),
        .out_valid (root_valid),
        .out_side  (root_side),
        .dist_res  (root_dist),
        .inv_dist  (root_inv)
    );

    assign out_ch.valid      = root_valid;
    assign out_ch.sep_x      = $signed(root_side.sep_x);
    assign out_ch.sep_y      = $signed(root_side.sep_y);
    assign out_ch.sep_z      = $signed(root_side.sep_z);
    assign out_ch.dist_sq    = root_side.dist_sq;
    assign out_ch.dist_res   = root_dist;
    assign out_ch.inv_dist   = root_inv;
    assign out_ch.coincident = (root_side.dist_sq == '0);

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
        else $error("input accepted while a result is held");

    a_coincident_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.coincident) |-> (out_ch.dist_res == '0 && out_ch.inv_dist == '1))
        else $error("coincident result without zero distance and saturated inverse");

    a_nonzero_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.dist_res != '0) |-> !out_ch.coincident)
        else $error("nonzero distance flagged as coincident");

endmodule
